FILE: rtl/assert_macros.svh
// shared assertion macros, clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ORF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ORF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define ORF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/orf_pkg.sv
package orf_pkg;

  localparam int RING_DEPTH_DEF  = 5;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 10;
  localparam int COUNT_W  = 3;

  localparam int UC_DEPTH = 7;
  localparam int UPC_W    = 3;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_SUM,
    OP_TEST,
    OP_DIV_INIT,
    OP_DIV,
    OP_OUT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_XFER,
    C_IDX_MORE,
    C_CNT_MORE,
    C_OUT_FREE
  } jcond_t;

  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    upc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic idx_last;
    logic cnt_last;
    logic out_busy;
  } dp_status_t;

  localparam upc_t PC_IDLE  = 3'd0;
  localparam upc_t PC_SUM   = 3'd1;
  localparam upc_t PC_TEST  = 3'd2;
  localparam upc_t PC_DIV   = 3'd4;
  localparam upc_t PC_OUT   = 3'd5;
  localparam upc_t PC_STALL = 3'd6;

  // jump taken when cond holds, else fall through to the next word
  localparam ctrl_word_t UCODE [UC_DEPTH] = '{
    '{op: OP_LOAD,     cond: C_NO_XFER,  target: PC_IDLE},
    '{op: OP_SUM,      cond: C_IDX_MORE, target: PC_SUM},
    '{op: OP_TEST,     cond: C_IDX_MORE, target: PC_TEST},
    '{op: OP_DIV_INIT, cond: C_NEVER,    target: PC_IDLE},
    '{op: OP_DIV,      cond: C_CNT_MORE, target: PC_DIV},
    '{op: OP_OUT,      cond: C_OUT_FREE, target: PC_IDLE},
    '{op: OP_NOP,      cond: C_ALWAYS,   target: PC_OUT}
  };

endpackage

FILE: rtl/orf_if.sv
interface orf_in_if;
  logic                         valid;
  logic                         ready;
  logic [orf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface orf_out_if;
  logic                        valid;
  logic                        ready;
  logic [orf_pkg::LEVEL_W-1:0] level;
  logic [orf_pkg::LEVEL_W-1:0] brightness;
  logic [orf_pkg::COUNT_W-1:0] kept_count;
  logic                        sample_rejected;

  modport source (output valid, output level, output brightness, output kept_count,
                  output sample_rejected, input ready);
  modport sink   (input valid, input level, input brightness, input kept_count,
                  input sample_rejected, output ready);
endinterface

FILE: rtl/orf_sequencer.sv
`include "assert_macros.svh"

module orf_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  orf_pkg::dp_status_t status,
  output orf_pkg::uop_t       op
);

  orf_pkg::upc_t       pc_r;
  orf_pkg::upc_t       pc_nxt;
  orf_pkg::ctrl_word_t word;
  logic                take;

  assign word = orf_pkg::UCODE[pc_r];
  assign op   = word.op;

  always_comb begin
    case (word.cond)
      orf_pkg::C_NEVER:    take = 1'b0;
      orf_pkg::C_ALWAYS:   take = 1'b1;
      orf_pkg::C_NO_XFER:  take = !in_valid;
      orf_pkg::C_IDX_MORE: take = !status.idx_last;
      orf_pkg::C_CNT_MORE: take = !status.cnt_last;
      orf_pkg::C_OUT_FREE: take = !status.out_busy;
      default:             take = 1'b0;
    endcase
    pc_nxt = take ? word.target : orf_pkg::upc_t'(pc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= orf_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `ORF_ASSERT_NXT(a_out_stall, (op == orf_pkg::OP_OUT) && status.out_busy, pc_r == orf_pkg::PC_STALL, "result stall did not hold the sequencer")

endmodule

FILE: rtl/orf_datapath.sv
`include "assert_macros.svh"

module orf_datapath #(
  parameter int RING_DEPTH  = orf_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = orf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  orf_pkg::uop_t                op,
  input  logic                         in_valid,
  input  logic [orf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         out_ready,
  output orf_pkg::dp_status_t          status,
  output logic                         out_valid,
  output logic [orf_pkg::LEVEL_W-1:0]  out_level,
  output logic [orf_pkg::LEVEL_W-1:0]  out_brightness,
  output logic [orf_pkg::COUNT_W-1:0]  out_kept_count,
  output logic                         out_sample_rejected
);

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int CMP_W  = SUM_W + 1;
  localparam int DCNT_W = $clog2(SAMPLE_BITS);

  localparam logic [IDX_W-1:0]       IDX_LAST   = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]       DEPTH_CNT  = CNT_W'(RING_DEPTH);
  localparam logic [CMP_W-1:0]       DEPTH_CMP  = CMP_W'(RING_DEPTH);
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  logic [SAMPLE_BITS-1:0] ring_r   [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] ring_nxt [RING_DEPTH];
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [SUM_W-1:0]       total_r, total_nxt;
  logic [SUM_W-1:0]       ksum_r, ksum_nxt;
  logic [CNT_W-1:0]       kept_r, kept_nxt;
  logic                   rej_r, rej_nxt;
  logic [CNT_W-1:0]       div_r, div_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] quo_r, quo_nxt;
  logic [DCNT_W-1:0]      cnt_r, cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [orf_pkg::LEVEL_W-1:0]  level_r, level_nxt;
  logic [orf_pkg::LEVEL_W-1:0]  bright_r, bright_nxt;
  logic [orf_pkg::COUNT_W-1:0]  okept_r, okept_nxt;
  logic                         orej_r, orej_nxt;

  logic [SAMPLE_BITS-1:0] x;
  logic                   in_rej;
  logic [CMP_W-1:0]       two_s;
  logic [CMP_W-1:0]       dx;
  logic                   keep;
  logic [SUM_W-1:0]       num;
  logic [CNT_W:0]         trial;
  logic [CNT_W:0]         diff;
  logic                   ge;
  logic                   out_busy;

  assign x        = ring_r[idx_r];
  assign in_rej   = |(in_sample >> SAMPLE_BITS);
  assign two_s    = {total_r, 1'b0};
  assign dx       = CMP_W'(x) * DEPTH_CMP;
  // 2S > D*x and S < 2D*x
  assign keep     = (two_s > dx) && ({1'b0, total_r} < {dx[CMP_W-2:0], 1'b0});
  assign num      = (kept_r != '0) ? ksum_r : total_r;
  assign trial    = {rem_r, quo_r[SAMPLE_BITS-1]};
  assign diff     = trial - {1'b0, div_r};
  assign ge       = trial >= {1'b0, div_r};
  assign out_busy = out_valid_r && !out_ready;

  assign status.idx_last = (idx_r == IDX_LAST);
  assign status.cnt_last = (cnt_r == '0);
  assign status.out_busy = out_busy;

  always_comb begin
    ring_nxt      = ring_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    ksum_nxt      = ksum_r;
    kept_nxt      = kept_r;
    rej_nxt       = rej_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    level_nxt     = level_r;
    bright_nxt    = bright_r;
    okept_nxt     = okept_r;
    orej_nxt      = orej_r;
    out_valid_nxt = out_busy;
    case (op)
      orf_pkg::OP_LOAD: begin
        if (in_valid) begin
          if (!in_rej) begin
            ring_nxt[slot_r] = SAMPLE_BITS'(in_sample);
            slot_nxt = (slot_r == IDX_LAST) ? '0 : IDX_W'(slot_r + 1'b1);
          end
          rej_nxt   = in_rej;
          total_nxt = '0;
          ksum_nxt  = '0;
          kept_nxt  = '0;
          idx_nxt   = '0;
        end
      end
      orf_pkg::OP_SUM: begin
        total_nxt = SUM_W'(total_r + SUM_W'(x));
        idx_nxt   = status.idx_last ? '0 : IDX_W'(idx_r + 1'b1);
      end
      orf_pkg::OP_TEST: begin
        if (keep) begin
          ksum_nxt = SUM_W'(ksum_r + SUM_W'(x));
          kept_nxt = CNT_W'(kept_r + 1'b1);
        end
        idx_nxt = status.idx_last ? '0 : IDX_W'(idx_r + 1'b1);
      end
      orf_pkg::OP_DIV_INIT: begin
        div_nxt = (kept_r != '0) ? kept_r : DEPTH_CNT;
        rem_nxt = CNT_W'(num >> SAMPLE_BITS);
        quo_nxt = num[SAMPLE_BITS-1:0];
        cnt_nxt = DCNT_W'(SAMPLE_BITS - 1);
      end
      orf_pkg::OP_DIV: begin
        rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_nxt = {quo_r[SAMPLE_BITS-2:0], ge};
        cnt_nxt = DCNT_W'(cnt_r - 1'b1);
      end
      orf_pkg::OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          level_nxt     = orf_pkg::LEVEL_W'(quo_r);
          bright_nxt    = orf_pkg::LEVEL_W'(FULL_SCALE - quo_r);
          okept_nxt     = orf_pkg::COUNT_W'(kept_r);
          orej_nxt      = rej_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_r      <= '{default: '0};
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ring_r      <= ring_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    total_r  <= total_nxt;
    ksum_r   <= ksum_nxt;
    kept_r   <= kept_nxt;
    rej_r    <= rej_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    level_r  <= level_nxt;
    bright_r <= bright_nxt;
    okept_r  <= okept_nxt;
    orej_r   <= orej_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_level           = level_r;
  assign out_brightness      = bright_r;
  assign out_kept_count      = okept_r;
  assign out_sample_rejected = orej_r;

  `ORF_ASSERT(a_slot_range, slot_r <= IDX_LAST, "write slot out of ring range")
  `ORF_ASSERT_IMP(a_div_rem, op == orf_pkg::OP_DIV, rem_r < div_r, "partial remainder not below divisor")
  `ORF_ASSERT_NXT(a_rej_hold, (op == orf_pkg::OP_LOAD) && in_valid && in_rej, $stable(slot_r) && rej_r, "rejected sample moved the write slot")
  `ORF_ASSERT_IMP(a_kept_max, op == orf_pkg::OP_DIV_INIT, kept_r <= DEPTH_CNT, "inlier count above ring depth")

endmodule

FILE: rtl/outlier_rejecting_average_filter_top.sv
// outlier rejecting average filter
// in_ch carries one 12-bit converter sample per transfer (valid/ready).
// a sample above the full-scale value is not stored; otherwise it goes into
// a ring of RING_DEPTH entries that starts at zero. every input transfer
// gives exactly one result on out_ch: the level (mean of the ring entries
// lying between half and twice the ring mean, or the plain ring mean when
// none do), full scale minus the level, the inlier count and a rejected flag.
// a small microcode table steps one shared datapath: one ring entry per
// cycle for the sum, one per cycle for the inlier test, then one quotient
// bit per cycle in a restoring divider.
// in_ch is ready only in the load step, so a new sample is taken only
// after the previous result has gone into the output register.
// the result sits in an output register; a stalled receiver holds the
// sequencer in its output step until the result is taken.
// reset clears the ring, the write slot, the sequencer and out valid.
module outlier_rejecting_average_filter_top #(
  parameter int RING_DEPTH  = orf_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = orf_pkg::SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  orf_in_if.sink       in_ch,
  orf_out_if.source    out_ch
);

  orf_pkg::uop_t       op;
  orf_pkg::dp_status_t status;

  assign in_ch.ready = (op == orf_pkg::OP_LOAD);

  orf_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .op       (op)
  );

  orf_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_valid            (in_ch.valid),
    .in_sample           (in_ch.sample),
    .out_ready           (out_ch.ready),
    .status              (status),
    .out_valid           (out_ch.valid),
    .out_level           (out_ch.level),
    .out_brightness      (out_ch.brightness),
    .out_kept_count      (out_ch.kept_count),
    .out_sample_rejected (out_ch.sample_rejected)
  );

endmodule
